### src/moving_average_filter_assert.svh
// assertion macros for the moving average filter
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MAF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MAF_ASSERT(name, prop, msg)
`define MAF_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

### src/mavg_pkg.sv
// package with sizes and codes of the moving average filter
`default_nettype none

package mavg_pkg;

  localparam int MaxWindow = 64;
  localparam int SampleW   = 32;
  localparam int CfgW      = 7;
  localparam int AddrW     = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int CntW      = $clog2(MaxWindow + 1);
  localparam int SumW      = SampleW + AddrW;
  localparam int IterW     = $clog2(SumW);

  localparam logic CmdFilter = 1'b0;
  localparam logic CmdClear  = 1'b1;

endpackage

`default_nettype wire

### src/moving_average_filter.sv
// boxcar moving average with a bit-serial divider
//
// Boxcar moving average over signed 32-bit samples. The window length is
// written through cfg_we_i/cfg_data_i; the user must write it only while the
// block is idle, the block itself does not enforce this. 0 counts as 1 and
// values above the history depth saturate to it. A filter transfer reads the
// history at its input transfer. It then takes an accumulate step, one divider
// step for each bit of the running sum (38 steps) and a step that loads the
// output register; the restoring divider produces one quotient bit per cycle.
// A clear transfer returns 0. The input is not ready while an item is in
// progress; a finished result waits in the output register and the next item
// is taken meanwhile, though that item holds in its last step until the
// register is free. Averages out of 32-bit range, which only occur after the
// window shrank, saturate.
`default_nettype none

module moving_average_filter (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [mavg_pkg::CfgW-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          command_i,
  input  wire  signed [mavg_pkg::SampleW-1:0] sample_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [mavg_pkg::SampleW-1:0] average_o
);
  import mavg_pkg::*;

  `include "moving_average_filter_assert.svh"

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_DONE} state_e;

  localparam logic [SumW-1:0]    NegLim = SumW'(1) << (SampleW - 1);
  localparam logic [SumW-1:0]    PosLim = NegLim - SumW'(1);
  localparam logic [SampleW-1:0] MinVal = SampleW'(1) << (SampleW - 1);
  localparam logic [SampleW-1:0] MaxVal = MinVal - SampleW'(1);

  state_e                      state_q;
  logic [CfgW-1:0]             window_q;
  logic [CntW-1:0]             filled_q;
  logic [AddrW-1:0]            wpos_q;
  logic signed [SumW-1:0]      sum_q;
  logic [CntW-1:0]             len_q;
  logic [AddrW-1:0]            pos_q;
  logic signed [SampleW-1:0]   sample_q;
  logic signed [SampleW-1:0]   rd_q;
  logic [SumW-1:0]             quo_q;
  logic [CntW-1:0]             rem_q;
  logic                        neg_q;
  logic [IterW-1:0]            iter_q;
  logic                        out_valid_q;
  logic signed [SampleW-1:0]   avg_q;

  logic signed [SampleW-1:0]   hist_mem [MaxWindow];

  logic                        in_xfer;
  logic [CntW-1:0]             len_d;
  logic [AddrW-1:0]            pos_d;
  logic [CntW-1:0]             pos_next;
  logic signed [SampleW-1:0]   old_val;
  logic signed [SumW-1:0]      sum_d;
  logic [SumW-1:0]             mag_d;
  logic [CntW:0]               shifted;
  logic [CntW:0]               trial;
  logic [SampleW-1:0]          avg_d;
  logic                        mem_we;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign average_o   = avg_q;
  assign mem_we      = (state_q == S_READ);

  // effective window length and the write slot after a possible shrink
  always_comb begin
    if (window_q == '0) begin
      len_d = CntW'(1);
    end else if (int'(window_q) > MaxWindow) begin
      len_d = CntW'(MaxWindow);
    end else begin
      len_d = CntW'(window_q);
    end
    pos_d = (CntW'(wpos_q) >= len_d) ? '0 : wpos_q;
  end

  // accumulate step
  always_comb begin
    old_val  = (CntW'(pos_q) < filled_q) ? rd_q : '0;
    sum_d    = sum_q + SumW'(sample_q) - SumW'(old_val);
    mag_d    = sum_d[SumW-1] ? SumW'(-sum_d) : SumW'(sum_d);
    pos_next = CntW'(pos_q) + CntW'(1);
  end

  // restoring divider step
  always_comb begin
    shifted = {rem_q, quo_q[SumW-1]};
    trial   = shifted - {1'b0, len_q};
  end

  // signed saturation of the quotient magnitude
  always_comb begin
    if (neg_q) begin
      avg_d = (quo_q > NegLim) ? MinVal : SampleW'(-quo_q[SampleW-1:0]);
    end else begin
      avg_d = (quo_q > PosLim) ? MaxVal : quo_q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[pos_q] <= sample_q;
    end
    if (in_xfer) begin
      rd_q <= hist_mem[pos_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      window_q    <= CfgW'(1);
      filled_q    <= '0;
      wpos_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      len_q       <= CntW'(1);
      pos_q       <= '0;
      sample_q    <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      iter_q      <= '0;
      avg_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (command_i == CmdClear) begin
              filled_q <= '0;
              wpos_q   <= '0;
              sum_q    <= '0;
              quo_q    <= '0;
              neg_q    <= 1'b0;
              state_q  <= S_DONE;
            end else begin
              len_q    <= len_d;
              pos_q    <= pos_d;
              sample_q <= sample_i;
              state_q  <= S_READ;
            end
          end
        end
        S_READ: begin
          sum_q <= sum_d;
          if ((CntW'(pos_q) == filled_q) && (int'(filled_q) < MaxWindow)) begin
            filled_q <= filled_q + CntW'(1);
          end
          wpos_q  <= (pos_next >= len_q) ? '0 : pos_next[AddrW-1:0];
          quo_q   <= mag_d;
          neg_q   <= sum_d[SumW-1];
          rem_q   <= '0;
          iter_q  <= IterW'(SumW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!trial[CntW]) begin
            rem_q <= trial[CntW-1:0];
            quo_q <= {quo_q[SumW-2:0], 1'b1};
          end else begin
            rem_q <= shifted[CntW-1:0];
            quo_q <= {quo_q[SumW-2:0], 1'b0};
          end
          if (iter_q == '0) begin
            state_q <= S_DONE;
          end else begin
            iter_q <= iter_q - IterW'(1);
          end
        end
        S_DONE: begin
          // output register free or being emptied this cycle
          if (!out_valid_q || out_ready_i) begin
            avg_q       <= avg_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `MAF_ASSERT(a_filled_bound, int'(filled_q) <= MaxWindow, "fill count beyond history depth")
  `MAF_ASSERT(a_wpos_in_fill, CntW'(wpos_q) <= filled_q, "write slot ahead of filled entries")
  `MAF_ASSERT(a_rem_below_div, (state_q != S_DIV) || (rem_q < len_q), "divider remainder too large")
  `MAF_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ready_o, "ready right after an input transfer")

endmodule

`default_nettype wire

### tb/tb_moving_average_filter.sv
// testbench for the boxcar moving average filter with a predicting scoreboard
`timescale 1ns / 100ps

module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int CycleLimit  = 400_000;
  localparam int RandomItems = 650;
  localparam logic signed [SampleW-1:0] SampleMax = 32'sh7fff_ffff;
  localparam logic signed [SampleW-1:0] SampleMin = 32'sh8000_0000;

  // expected averages of a boxcar filter, kept in step with the accepted transfers
  class boxcar_scoreboard;
    localparam longint AvgMax = 64'sd2147483647;
    localparam longint AvgMin = -64'sd2147483648;

    logic [CfgW-1:0]            win_len = 1;
    logic signed [SampleW-1:0]  hist [MaxWindow];
    int unsigned                filled = 0;
    int unsigned                wpos = 0;
    longint                     acc = 0;
    logic signed [SampleW-1:0]  expected_averages [$];
    int unsigned                errors = 0;
    int unsigned                samples = 0;
    int unsigned                clears = 0;
    int unsigned                saturated = 0;

    function void set_window(logic [CfgW-1:0] len);
      win_len = len;
    endfunction

    function int unsigned pending();
      return expected_averages.size();
    endfunction

    function void note_transfer(logic cmd, logic signed [SampleW-1:0] smp);
      int unsigned len;
      int unsigned pos;
      longint      old_val;
      longint      avg;
      if (cmd == CmdClear) begin
        filled = 0;
        wpos = 0;
        acc = 0;
        clears++;
        expected_averages.push_back('0);
        return;
      end
      len = 32'(win_len);
      if (len == 0) len = 1;
      if (len > MaxWindow) len = MaxWindow;
      // position left over from a longer window wraps first
      pos = wpos;
      if (pos >= len) pos = 0;
      old_val = (pos < filled) ? longint'(hist[pos[AddrW-1:0]]) : 64'sd0;
      acc += longint'(smp) - old_val;
      hist[pos[AddrW-1:0]] = smp;
      if (pos == filled && filled < MaxWindow) filled++;
      pos++;
      if (pos >= len) pos = 0;
      wpos = pos;
      avg = acc / longint'(len);
      if (avg > AvgMax) begin
        avg = AvgMax;
        saturated++;
      end else if (avg < AvgMin) begin
        avg = AvgMin;
        saturated++;
      end
      samples++;
      expected_averages.push_back(avg[SampleW-1:0]);
    endfunction

    function void check_average(logic signed [SampleW-1:0] actual);
      logic signed [SampleW-1:0] want;
      if (expected_averages.size() == 0) begin
        $display("%0t: average with no transfer pending, expected none, actual %0d",
                 $time, actual);
        errors++;
        return;
      end
      want = expected_averages.pop_front();
      if (actual !== want) begin
        $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CfgW-1:0]            cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       command_i = CmdFilter;
  logic signed [SampleW-1:0]  sample_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SampleW-1:0]  average_o;

  boxcar_scoreboard sb = new();
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings_used = 0;
  int unsigned random_items = 0;

  moving_average_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .average_o   (average_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d averages outstanding", $time, sb.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_average(average_o);
    end
  end

  task automatic send_item(input logic cmd, input logic [SampleW-1:0] smp);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_transfer(cmd, smp);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // window length only changes while nothing is in flight
  task automatic write_window(input logic [CfgW-1:0] len);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(len);
    settings_used++;
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return $urandom_range(0, 15) - 8;
      3:       return SampleMax - $urandom_range(0, 255);
      4:       return SampleMin + $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned run_len;
    int unsigned pick;
    logic [CfgW-1:0] len;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // reset window of one passes samples straight through
    send_item(CmdFilter, SampleMax);
    send_item(CmdFilter, SampleMin);
    // zero length behaves as one
    write_window(0);
    send_item(CmdFilter, -1);
    send_item(CmdFilter, 5);
    // full scale sums and truncation toward zero
    write_window(4);
    repeat (4) send_item(CmdFilter, SampleMax);
    send_item(CmdFilter, SampleMin);
    send_item(CmdClear, SampleMax);
    send_item(CmdFilter, -7);
    send_item(CmdFilter, 3);
    // shrinking the window leaves a sum beyond 32 bits: saturate high, then low
    write_window(2);
    send_item(CmdFilter, SampleMax);
    send_item(CmdFilter, SampleMax);
    write_window(1);
    send_item(CmdFilter, SampleMax);
    send_item(CmdClear, 0);
    write_window(2);
    send_item(CmdFilter, SampleMin);
    send_item(CmdFilter, SampleMin);
    write_window(1);
    send_item(CmdFilter, SampleMin);
    // oversized length saturates, then a shrink below the write position
    write_window(127);
    send_item(CmdClear, 0);
    repeat (5) send_item(CmdFilter, pick_sample());
    write_window(3);
    send_item(CmdFilter, pick_sample());
    send_item(CmdFilter, pick_sample());

    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 0;
        1:       len = 1;
        2:       len = CfgW'(MaxWindow);
        3:       len = CfgW'($urandom_range(MaxWindow + 1, 127));
        4:       len = 2;
        default: len = CfgW'($urandom_range(1, MaxWindow));
      endcase
      write_window(len);
      no_idle = ($urandom_range(0, 3) == 0);
      run_len = $urandom_range(8, 70);
      repeat (run_len) begin
        if ($urandom_range(0, 24) == 0) send_item(CmdClear, $urandom());
        else send_item(CmdFilter, pick_sample());
        random_items++;
      end
      no_idle = 1'b0;
    end

    drain_results();
    repeat (50) @(posedge clk_i);

    $display("covered %0d samples and %0d clears across %0d window settings",
             sb.samples, sb.clears, settings_used);
    $display("%0d averages hit the 32-bit limits", sb.saturated);
    if (sb.pending() != 0)
      $display("%0t: %0d averages never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/mavg_pkg.sv
src/moving_average_filter.sv
tb/tb_moving_average_filter.sv
